// ===== rtl/murmur2_hash_stream_core_assert.svh =====
// Assertion macros shared by the hash stream core modules.
`ifndef MURMUR2_HASH_STREAM_CORE_ASSERT_SVH
`define MURMUR2_HASH_STREAM_CORE_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define MHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define MHS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/mhs_pkg.sv =====
// Shared constants and types of the MurmurHash2 stream core.
package mhs_pkg;

    // Hash constants
    localparam logic [31:0] MIX_M = 32'h5bd1_e995;
    localparam int unsigned MIX_R = 24;
    localparam int unsigned FIN_A = 13;
    localparam int unsigned FIN_B = 15;

    // Stream widths
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 32;

    // Classified chunk passed from the front to the back
    typedef struct packed {
        logic        first;      // start a new string from start_hash
        logic [31:0] start_hash; // seed xor total length
        logic [31:0] word;       // chunk bytes, unused bytes cleared on a short chunk
        logic        full;       // four valid bytes
        logic        nonzero;    // at least one valid byte
        logic        last;       // finalize and emit after this chunk
    } t_cmd;

    // Back sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_FINAL
    } t_back_state;

endpackage

// ===== rtl/mhs_front.sv =====
// Front end: seed register, input acceptance and chunk classification.
module mhs_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [31:0]                         i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mhs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                s_axis_tuser,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output mhs_pkg::t_cmd                       o_q_cmd
);

    logic [31:0] r_seed;
    logic [31:0] total_length;
    logic [31:0] chunk_word;
    logic [2:0]  chunk_bytes;
    logic [31:0] short_word;
    logic        is_full;

    // Hold the seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_wr_en) begin
            r_seed <= i_cfg_wr_data;
        end
    end

    // Unpack the item
    assign total_length = s_axis_tdata[31:0];
    assign chunk_word   = s_axis_tdata[63:32];
    assign chunk_bytes  = s_axis_tdata[66:64];

    // Counts of four and above are a full chunk
    assign is_full = chunk_bytes[2];

    // Drop the unused bytes of a short chunk
    always_comb begin
        unique case (chunk_bytes[1:0])
            2'd0:    short_word = 32'h0000_0000;
            2'd1:    short_word = {24'h00_0000, chunk_word[7:0]};
            2'd2:    short_word = {16'h0000, chunk_word[15:0]};
            2'd3:    short_word = {8'h00, chunk_word[23:0]};
            default: short_word = 32'h0000_0000;
        endcase
    end

    // Classify and push into the queue
    assign s_axis_tready      = !i_q_full;
    assign o_q_push           = s_axis_tvalid && !i_q_full;
    assign o_q_cmd.first      = s_axis_tuser;
    assign o_q_cmd.start_hash = r_seed ^ total_length;
    assign o_q_cmd.word       = is_full ? chunk_word : short_word;
    assign o_q_cmd.full       = is_full;
    assign o_q_cmd.nonzero    = is_full || (chunk_bytes[1:0] != 2'd0);
    assign o_q_cmd.last       = s_axis_tlast || !is_full;

endmodule

// ===== rtl/mhs_queue.sv =====
// Small register queue of classified chunks between front and back.
`include "murmur2_hash_stream_core_assert.svh"

module mhs_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mhs_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mhs_pkg::t_cmd  o_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mhs_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `MHS_ASSERT(a_count_bound, r_count <= CNT_W'(DEPTH), "queue count above depth")
    `MHS_ASSERT(a_ptr_gap, (r_count == '0 || r_count == CNT_W'(DEPTH)) |-> r_wr_ptr == r_rd_ptr, "queue pointers disagree with count")

endmodule

// ===== rtl/mhs_back.sv =====
// Back end: chunk mixing, final mix and the output register.
`include "murmur2_hash_stream_core_assert.svh"

module mhs_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  mhs_pkg::t_cmd                       i_q_cmd,
    output logic                                o_q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mhs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    mhs_pkg::t_back_state r_state;
    mhs_pkg::t_back_state n_state;
    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] r_kmul;
    logic [31:0] n_kmul;
    logic [31:0] r_hacc;
    logic [31:0] n_hacc;
    logic        r_full;
    logic        n_full;
    logic        r_last;
    logic        n_last;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out_data;
    logic [31:0] n_out_data;

    logic [31:0] h_in;
    logic [31:0] h_xor;
    logic [31:0] h_mul;
    logic [31:0] k_shx;
    logic [31:0] k_mul;
    logic [31:0] h_mix;
    logic [31:0] f_shx;
    logic [31:0] f_mul;
    logic        fin_go;

    // Load stage: first multiplies on the chunk and on the hash
    assign h_in  = i_q_cmd.first ? i_q_cmd.start_hash : r_hash;
    assign h_xor = i_q_cmd.full ? h_in : (h_in ^ i_q_cmd.word);
    assign h_mul = h_xor * mhs_pkg::MIX_M;

    // Mix stage: second chunk multiply and merge
    assign k_shx = r_kmul ^ (r_kmul >> mhs_pkg::MIX_R);
    assign k_mul = k_shx * mhs_pkg::MIX_M;
    assign h_mix = r_full ? (r_hacc ^ k_mul) : r_hacc;

    // Final stage
    assign f_shx  = r_hacc ^ (r_hacc >> mhs_pkg::FIN_A);
    assign f_mul  = f_shx * mhs_pkg::MIX_M;
    assign fin_go = (r_state == mhs_pkg::ST_FINAL) && (!r_out_valid || m_axis_tready);

    // Sequence one item at a time
    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_kmul      = r_kmul;
        n_hacc      = r_hacc;
        n_full      = r_full;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_q_pop     = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mhs_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_kmul  = i_q_cmd.word * mhs_pkg::MIX_M;
                    n_hacc  = i_q_cmd.nonzero ? h_mul : h_in;
                    n_full  = i_q_cmd.full;
                    n_last  = i_q_cmd.last;
                    n_state = mhs_pkg::ST_MIX;
                end
            end
            mhs_pkg::ST_MIX: begin
                if (r_last) begin
                    n_hacc  = h_mix;
                    n_state = mhs_pkg::ST_FINAL;
                end else begin
                    n_hash  = h_mix;
                    n_state = mhs_pkg::ST_IDLE;
                end
            end
            mhs_pkg::ST_FINAL: begin
                if (fin_go) begin
                    n_out_data  = f_mul ^ (f_mul >> mhs_pkg::FIN_B);
                    n_out_valid = 1'b1;
                    n_hash      = '0;
                    n_state     = mhs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mhs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhs_pkg::ST_IDLE;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_kmul     <= n_kmul;
        r_hacc     <= n_hacc;
        r_full     <= n_full;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `MHS_ASSERT(a_final_holds, (r_state == mhs_pkg::ST_FINAL && r_out_valid && !m_axis_tready) |=> r_state == mhs_pkg::ST_FINAL, "final mix left while output stalled")
    `MHS_ASSERT(a_hash_cleared, fin_go |=> (r_hash == '0 && r_out_valid), "hash not cleared after emission")

endmodule

// ===== rtl/murmur2_hash_stream_core.sv =====
// A last chunk goes through the queue and the IDLE, MIX and FINAL states of the back
// sequencer, which registers its hash onto m_axis. The back takes one chunk at a time:
// IDLE then MIX, plus FINAL to close a string, due to the dependent 32-bit hash multiply.
// The front keeps taking items into a QUEUE_DEPTH entry queue while the back works.
// Reset: i_rst_n synchronous, active low; clears the seed to 0, the running hash
// to 0, the queue and the output valid flag.
module murmur2_hash_stream_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [31:0]                         i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // total_length[31:0], chunk_word[63:32], chunk_bytes[66:64], zero fill[71:67]
    input  logic [mhs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    // first_chunk[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hash_value[31:0]
    output logic [mhs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    mhs_pkg::t_cmd q_in_cmd;
    mhs_pkg::t_cmd q_out_cmd;

    mhs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in_cmd)
    );

    mhs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    mhs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_out_cmd),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== test/murmur2_hash_stream_core_tb.sv =====
// Self-checking testbench for the MurmurHash2 stream core: directed, random and back-pressure runs.
`timescale 1ns / 1ps

module murmur2_hash_stream_core_tb;

    localparam int unsigned SETTLE_CYCLES = 8;     // output latency plus margin
    localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int unsigned PHASE_ITEMS   = 330;

    // One input item as the block sees it
    typedef struct packed {
        logic        first;
        logic [31:0] len;
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } t_chunk;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_wr_en;
    logic [31:0]                     i_cfg_wr_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // total_length[31:0], chunk_word[63:32], chunk_bytes[66:64], zero fill[71:67]
    logic [mhs_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tlast;
    // first_chunk[0]
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // hash_value[31:0]
    logic [mhs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor state and expected hashes
    logic [31:0] seed_copy;
    logic [31:0] open_hash;
    logic [31:0] pending_hashes[$];

    int unsigned items_sent;
    int unsigned phase_items;
    int unsigned hashes_checked;
    int unsigned mismatches;
    int unsigned seeds_written;
    int unsigned stall_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_grants;
    int unsigned hold_seen;
    int unsigned hold_left;

    murmur2_hash_stream_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock
    always #5 i_clk = ~i_clk;

    // Fold one accepted chunk into the running hash; queue the hash when the string closes
    task automatic fold_chunk(input t_chunk c);
        logic [31:0] h;
        logic [31:0] k;
        logic [2:0]  nb;
        logic        closes;
        nb     = (c.nbytes > 3'd4) ? 3'd4 : c.nbytes;
        h      = c.first ? (seed_copy ^ c.len) : open_hash;
        closes = c.last;
        if (nb == 3'd4) begin
            k = c.word * mhs_pkg::MIX_M;
            k = k ^ (k >> mhs_pkg::MIX_R);
            k = k * mhs_pkg::MIX_M;
            h = h * mhs_pkg::MIX_M;
            h = h ^ k;
        end else begin
            // a short chunk always ends the string
            closes = 1'b1;
            if (nb != 3'd0) begin
                h = h ^ (c.word & (32'hFFFF_FFFF >> (8 * (4 - nb))));
                h = h * mhs_pkg::MIX_M;
            end
        end
        if (!closes) begin
            open_hash = h;
        end else begin
            h = h ^ (h >> mhs_pkg::FIN_A);
            h = h * mhs_pkg::MIX_M;
            h = h ^ (h >> mhs_pkg::FIN_B);
            open_hash = 32'd0;
            pending_hashes.push_back(h);
        end
    endtask

    function automatic t_chunk mk(input logic f, input logic [31:0] len,
                                  input logic [31:0] word, input logic [2:0] nb,
                                  input logic l);
        t_chunk c;
        c.first  = f;
        c.len    = len;
        c.word   = word;
        c.nbytes = nb;
        c.last   = l;
        return c;
    endfunction

    // Offer one item after a random gap and hold it until accepted; entered and left at a negedge
    task automatic send_chunk(input t_chunk c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, c.nbytes, c.word, c.len};
        s_axis_tlast  <= c.last;
        s_axis_tuser  <= c.first;
        do @(posedge i_clk); while (!s_axis_tready);
        fold_chunk(c);
        items_sent++;
        phase_items++;
        @(negedge i_clk);
    endtask

    // Send one well-formed string of n_bytes, with a few legal oddities mixed in
    task automatic send_string(input int unsigned n_bytes, input logic [31:0] len_field);
        t_chunk      c;
        int unsigned left;
        logic        first;
        logic        done;
        left  = n_bytes;
        first = 1'b1;
        done  = 1'b0;
        while (!done) begin
            done     = (left <= 4);
            c.first  = first;
            c.len    = first ? len_field : $urandom;
            c.word   = $urandom;
            if (left >= 4) begin
                c.nbytes = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
                c.last   = done;
            end else begin
                c.nbytes = 3'(left);
                // short chunk left unmarked now and then
                c.last   = ($urandom_range(0, 3) != 0);
            end
            send_chunk(c);
            left  = (left >= 4) ? left - 4 : 0;
            first = 1'b0;
        end
    endtask

    // Drop valid, wait for every expected hash, then let the pipe settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_hashes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        seed_copy = value;
        seeds_written++;
        @(negedge i_clk);
    endtask

    // Boundary values and every corner the core must handle
    task automatic test_directed;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_chunk(mk(1'b1, 32'd0, $urandom, 3'd0, 1'b1));              // empty string
        send_chunk(mk(1'b1, 32'd0, $urandom, 3'd0, 1'b0));              // empty, not marked last
        send_chunk(mk(1'b1, 32'd1, 32'hFFFF_FFA5, 3'd1, 1'b1));         // junk above valid bytes
        send_chunk(mk(1'b1, 32'd2, 32'hDEAD_BEEF, 3'd2, 1'b0));         // short chunk ends string
        send_chunk(mk(1'b1, 32'd3, 32'hFFFF_FFFF, 3'd3, 1'b1));
        send_chunk(mk(1'b1, 32'd4, 32'h0000_0000, 3'd4, 1'b1));
        send_chunk(mk(1'b1, 32'd11, 32'h6463_6261, 3'd4, 1'b0));        // three-chunk string
        send_chunk(mk(1'b0, 32'd0, 32'h6867_6665, 3'd4, 1'b0));
        send_chunk(mk(1'b0, 32'd0, 32'hFF6B_6A69, 3'd3, 1'b1));
        send_chunk(mk(1'b1, 32'd12, $urandom, 3'd5, 1'b0));             // oversized byte counts
        send_chunk(mk(1'b0, 32'd0, $urandom, 3'd6, 1'b0));
        send_chunk(mk(1'b0, 32'd0, $urandom, 3'd7, 1'b1));
        send_chunk(mk(1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 3'd4, 1'b0)); // no string open
        send_chunk(mk(1'b0, 32'd0, 32'h0000_0055, 3'd1, 1'b1));
        send_chunk(mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b1)); // length mismatch
        send_chunk(mk(1'b1, 32'd8, $urandom, 3'd4, 1'b0));              // restart mid-string
        send_chunk(mk(1'b1, 32'd4, $urandom, 3'd4, 1'b1));
        drain();
        write_seed(32'hFFFF_FFFF);
        send_chunk(mk(1'b1, 32'd0, 32'd0, 3'd0, 1'b1));
        send_chunk(mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b1));
        send_chunk(mk(1'b1, 32'd2, 32'h0000_FFFF, 3'd2, 1'b1));
        drain();
        write_seed(32'h9747_B28C);
        send_chunk(mk(1'b1, 32'd4, 32'h6463_6261, 3'd4, 1'b1));
        drain();
    endtask

    // Mostly well-formed strings with random content, some raw noise
    task automatic test_random_phase(input logic [31:0] seed, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        int unsigned n;
        t_chunk      c;
        write_seed(seed);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_items    = 0;
        while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
                send_string(n, ($urandom_range(0, 9) == 0) ? $urandom : n);
            end else begin
                c = mk(1'($urandom), $urandom, $urandom, 3'($urandom), 1'($urandom));
                send_chunk(c);
            end
        end
        drain();
    endtask

    // Hold the receiver off for a long stretch while strings keep coming
    task automatic test_backpressure;
        int unsigned i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_grants++;
        for (i = 0; i < 12; i++) send_string($urandom_range(0, 12), $urandom);
        drain();
    endtask

    // Receiver readiness: random stalls plus the requested hold-off
    always @(negedge i_clk) begin
        if (hold_seen != hold_grants) begin
            hold_seen = hold_grants;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each delivered hash with the oldest one expected
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t unexpected hash: expected none, actual %h", $time, m_axis_tdata);
                mismatches++;
            end else begin
                if (m_axis_tdata !== pending_hashes[0]) begin
                    $display("%0t hash_value mismatch: expected %h, actual %h",
                             $time, pending_hashes[0], m_axis_tdata);
                    mismatches++;
                end
                void'(pending_hashes.pop_front());
                hashes_checked++;
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t timeout with %0d hashes outstanding", $time, pending_hashes.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = 32'd0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        seed_copy      = 32'd0;
        open_hash      = 32'd0;
        items_sent     = 0;
        phase_items    = 0;
        hashes_checked = 0;
        mismatches     = 0;
        seeds_written  = 0;
        stall_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_grants    = 0;
        hold_seen      = 0;
        hold_left      = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_phase($urandom, 0, 0);
        test_random_phase(32'hFFFF_FFFF, 57, 0);
        test_random_phase(32'd0, 0, 57);
        test_backpressure();
        test_random_phase($urandom, 17, 17);

        if (pending_hashes.size() != 0) begin
            $display("%0t %0d expected hashes never arrived", $time, pending_hashes.size());
            mismatches++;
        end
        $display("Covered %0d chunks and %0d hashes over %0d seed writes,",
                 items_sent, hashes_checked, seeds_written);
        $display("with four idle mixes and one long output hold-off.");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
